@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the quadratic root solver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond implies prop in the same cycle, outside reset
`define QRS_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error("assertion failed");

// cond implies prop in the next cycle, outside reset
`define QRS_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error("assertion failed");

// prop holds at every edge, reset included
`define QRS_ASSERT_ALW(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) else $error("assertion failed");

`endif

@@ src/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, status codes and cell data types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * COEF_BITS;
    localparam int DELTA_W   = PROD_W + 3;
    localparam int ROOT_W    = (DELTA_W - 1 + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SQ_REM_W  = ROOT_W + 3;
    localparam int NB_W      = COEF_BITS + FRAC_BITS + 1;
    localparam int SUM_W     = ROOT_W + 2;
    localparam int NUM_W     = SUM_W - 1;
    localparam int DEN_W     = COEF_BITS + 1;
    localparam int OUT_W     = 33;
    localparam int SQ_CELLS  = ROOT_W;
    localparam int DIV_CELLS = NUM_W;

    typedef logic [1:0] t_status;
    localparam t_status ST_TWO    = 2'd0;
    localparam t_status ST_DOUBLE = 2'd1;
    localparam t_status ST_NONE   = 2'd2;
    localparam t_status ST_AZERO  = 2'd3;

    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic signed [NB_W-1:0]  nb;
        logic                    a_neg;
        logic [DEN_W-1:0]        den;
    } t_sq_side;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [RAD_W-1:0]    rad;
    } t_sq_data;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic             neg;
    } t_div_lane;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [DEN_W-1:0] den;
    } t_div_side;

endpackage

@@ src/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit step of the square root chain: settles one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  qrs_pkg::t_sq_side i_side,
    input  qrs_pkg::t_sq_data i_dat,
    output qrs_pkg::t_sq_side o_side,
    output qrs_pkg::t_sq_data o_dat
);
    import qrs_pkg::*;

    t_sq_side r_side;
    t_sq_data r_dat;
    t_sq_data n_dat;
    logic [SQ_REM_W-1:0] w_rem_sh;
    logic [SQ_REM_W-1:0] w_trial;

    always_comb begin
        w_rem_sh  = {i_dat.rem[SQ_REM_W-3:0], i_dat.rad[RAD_W-1 -: 2]};
        w_trial   = {{(SQ_REM_W-ROOT_W-2){1'b0}}, i_dat.root, 2'b01};
        n_dat.rad = {i_dat.rad[RAD_W-3:0], 2'b00};
        if (w_rem_sh >= w_trial) begin
            n_dat.rem  = w_rem_sh - w_trial;
            n_dat.root = {i_dat.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_dat.rem  = w_rem_sh;
            n_dat.root = {i_dat.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
        if (i_en) begin
            r_dat <= n_dat;
        end
    end

    assign o_side = r_side;
    assign o_dat  = r_dat;

endmodule

@@ src/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step for both root lanes: settles one quotient bit.
// ----------------------------------------------------------------------------
module qrs_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  qrs_pkg::t_div_side i_side,
    input  qrs_pkg::t_div_lane i_plus,
    input  qrs_pkg::t_div_lane i_minus,
    output qrs_pkg::t_div_side o_side,
    output qrs_pkg::t_div_lane o_plus,
    output qrs_pkg::t_div_lane o_minus
);
    import qrs_pkg::*;

    t_div_side r_side;
    t_div_lane r_plus;
    t_div_lane r_minus;
    t_div_lane n_plus;
    t_div_lane n_minus;

    function automatic t_div_lane step(input t_div_lane l, input logic [DEN_W-1:0] den);
        t_div_lane   s;
        logic [DEN_W:0] sh;
        sh    = {l.rem, l.num[NUM_W-1]};
        s.num = {l.num[NUM_W-2:0], 1'b0};
        s.neg = l.neg;
        if (sh >= {1'b0, den}) begin
            s.rem = DEN_W'(sh - {1'b0, den});
            s.quo = {l.quo[NUM_W-2:0], 1'b1};
        end else begin
            s.rem = sh[DEN_W-1:0];
            s.quo = {l.quo[NUM_W-2:0], 1'b0};
        end
        return s;
    endfunction

    assign n_plus  = step(i_plus, i_side.den);
    assign n_minus = step(i_minus, i_side.den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
        if (i_en) begin
            r_plus  <= n_plus;
            r_minus <= n_minus;
        end
    end

    assign o_side  = r_side;
    assign o_plus  = r_plus;
    assign o_minus = r_minus;

endmodule

@@ src/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed Q17.16 with a status code.
// ----------------------------------------------------------------------------
// Takes one coefficient set per cycle while o_stall is low. Each set passes a
// product stage, a discriminant stage, a 33-cell square root chain (one root
// bit per cell), a numerator stage, a 34-cell divider chain (one quotient bit
// per cell, both roots side by side) and an output register. An output stall
// with o_valid high freezes all stages and shows on o_stall in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadratic_root_solver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [qrs_pkg::COEF_BITS-1:0] i_coef_a,
    input  logic signed [qrs_pkg::COEF_BITS-1:0] i_coef_b,
    input  logic signed [qrs_pkg::COEF_BITS-1:0] i_coef_c,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [qrs_pkg::OUT_W-1:0]    o_root_plus,
    output logic signed [qrs_pkg::OUT_W-1:0]    o_root_minus,
    output qrs_pkg::t_status                    o_status
);
    import qrs_pkg::*;

    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'((64'sd1 <<< (OUT_W-1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = (SUM_W+1)'(-(64'sd1 <<< (OUT_W-1)));

    logic w_en;

    logic                        r1_valid;
    logic signed [PROD_W-1:0]    r1_bb;
    logic signed [PROD_W-1:0]    r1_ac;
    logic signed [COEF_BITS-1:0] r1_a;
    logic signed [COEF_BITS-1:0] r1_b;

    logic signed [DELTA_W-1:0]   w_delta;
    logic [COEF_BITS-1:0]        w_a_mag;
    t_sq_side                    n2_side;
    t_sq_data                    n2_dat;

    t_sq_side w_sq_side [0:SQ_CELLS];
    t_sq_data w_sq_dat  [0:SQ_CELLS];

    logic signed [SUM_W-1:0] w_sum_p;
    logic signed [SUM_W-1:0] w_sum_m;
    logic signed [SUM_W-1:0] w_abs_p;
    logic signed [SUM_W-1:0] w_abs_m;
    t_div_side n3_side;
    t_div_lane n3_plus;
    t_div_lane n3_minus;

    t_div_side w_dv_side  [0:DIV_CELLS];
    t_div_lane w_dv_plus  [0:DIV_CELLS];
    t_div_lane w_dv_minus [0:DIV_CELLS];

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_root_plus;
    logic signed [OUT_W-1:0] r_root_minus;
    t_status                 r_status;

    function automatic logic signed [OUT_W-1:0] finish(input t_div_lane l);
        logic signed [SUM_W:0] v;
        v = l.neg ? -$signed({2'b00, l.quo}) : $signed({2'b00, l.quo});
        if (v > SAT_HI) begin
            v = SAT_HI;
        end else if (v < SAT_LO) begin
            v = SAT_LO;
        end
        return v[OUT_W-1:0];
    endfunction

    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    // products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
        if (w_en) begin
            r1_bb <= i_coef_b * i_coef_b;
            r1_ac <= i_coef_a * i_coef_c;
            r1_a  <= i_coef_a;
            r1_b  <= i_coef_b;
        end
    end

    // discriminant and classification
    always_comb begin
        w_delta = DELTA_W'(r1_bb) - (DELTA_W'(r1_ac) <<< 2);
        w_a_mag = r1_a[COEF_BITS-1] ? COEF_BITS'(-r1_a) : COEF_BITS'(r1_a);
        n2_side.valid = r1_valid;
        n2_side.nb    = -$signed({r1_b[COEF_BITS-1], r1_b, {FRAC_BITS{1'b0}}});
        n2_side.a_neg = r1_a[COEF_BITS-1];
        n2_side.den   = {w_a_mag, 1'b0};
        if (r1_a == '0) begin
            n2_side.status = ST_AZERO;
        end else if (w_delta[DELTA_W-1]) begin
            n2_side.status = ST_NONE;
        end else if (w_delta == '0) begin
            n2_side.status = ST_DOUBLE;
        end else begin
            n2_side.status = ST_TWO;
        end
        n2_dat.rem  = '0;
        n2_dat.root = '0;
        n2_dat.rad  = w_delta[DELTA_W-1] ? '0
                    : {w_delta[RAD_W-2*FRAC_BITS-1:0], {(2*FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_sq_side[0].valid <= 1'b0;
        end else if (w_en) begin
            w_sq_side[0] <= n2_side;
        end
        if (w_en) begin
            w_sq_dat[0] <= n2_dat;
        end
    end

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_sq_side[g]),
            .i_dat   (w_sq_dat[g]),
            .o_side  (w_sq_side[g+1]),
            .o_dat   (w_sq_dat[g+1])
        );
    end

    // numerators, signs and magnitudes
    always_comb begin
        w_sum_p = SUM_W'(w_sq_side[SQ_CELLS].nb) + $signed({2'b00, w_sq_dat[SQ_CELLS].root});
        w_sum_m = SUM_W'(w_sq_side[SQ_CELLS].nb) - $signed({2'b00, w_sq_dat[SQ_CELLS].root});
        w_abs_p = w_sum_p[SUM_W-1] ? -w_sum_p : w_sum_p;
        w_abs_m = w_sum_m[SUM_W-1] ? -w_sum_m : w_sum_m;
        n3_side.valid  = w_sq_side[SQ_CELLS].valid;
        n3_side.status = w_sq_side[SQ_CELLS].status;
        n3_side.den    = w_sq_side[SQ_CELLS].den;
        n3_plus.rem    = '0;
        n3_plus.quo    = '0;
        n3_plus.num    = w_abs_p[NUM_W-1:0];
        n3_plus.neg    = w_sum_p[SUM_W-1] ^ w_sq_side[SQ_CELLS].a_neg;
        n3_minus.rem   = '0;
        n3_minus.quo   = '0;
        n3_minus.num   = w_abs_m[NUM_W-1:0];
        n3_minus.neg   = w_sum_m[SUM_W-1] ^ w_sq_side[SQ_CELLS].a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_dv_side[0].valid <= 1'b0;
        end else if (w_en) begin
            w_dv_side[0] <= n3_side;
        end
        if (w_en) begin
            w_dv_plus[0]  <= n3_plus;
            w_dv_minus[0] <= n3_minus;
        end
    end

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_dv
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_dv_side[g]),
            .i_plus  (w_dv_plus[g]),
            .i_minus (w_dv_minus[g]),
            .o_side  (w_dv_side[g+1]),
            .o_plus  (w_dv_plus[g+1]),
            .o_minus (w_dv_minus[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_side[DIV_CELLS].valid;
        end
        if (w_en) begin
            r_status <= w_dv_side[DIV_CELLS].status;
            if (w_dv_side[DIV_CELLS].status == ST_NONE
                || w_dv_side[DIV_CELLS].status == ST_AZERO) begin
                r_root_plus  <= '0;
                r_root_minus <= '0;
            end else begin
                r_root_plus  <= finish(w_dv_plus[DIV_CELLS]);
                r_root_minus <= finish(w_dv_minus[DIV_CELLS]);
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_root_plus  = r_root_plus;
    assign o_root_minus = r_root_minus;
    assign o_status     = r_status;

    `QRS_ASSERT_IMP(a_no_root_zero, o_valid && (o_status == ST_NONE || o_status == ST_AZERO), o_root_plus == '0 && o_root_minus == '0)
    `QRS_ASSERT_IMP(a_double_equal, o_valid && o_status == ST_DOUBLE, o_root_plus == o_root_minus)
    `QRS_ASSERT_NXT(a_stall_freeze, o_stall, w_sq_side[0] == $past(w_sq_side[0]))
    `QRS_ASSERT_ALW(a_reset_idle, !i_rst_n |=> !o_valid)

endmodule
